[design/abkf_pkg.sv]
// ----------------------------------------------------------------------------
// abkf_pkg
// Shared widths, register indexes and sequencer codes for the per-axis
// two-state accelerometer Kalman filter.
// ----------------------------------------------------------------------------
package abkf_pkg;

    localparam int AXIS_W    = 2;
    localparam int ACCEL_W   = 32;
    localparam int NOISE_W   = 30;
    localparam int CFG_IDX_W = 2;
    localparam int DIV_STEPS = 32;

    localparam logic [CFG_IDX_W-1:0] REG_ACCEL_NOISE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BIAS_NOISE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MEAS_NOISE  = 2'd2;

    localparam logic signed [ACCEL_W-1:0] Q30_ONE = 32'sh4000_0000;
    localparam logic [NOISE_W-1:0] ACCEL_NOISE_RST = 30'd1073742;
    localparam logic [NOISE_W-1:0] BIAS_NOISE_RST  = 30'd10737;
    localparam logic [NOISE_W-1:0] MEAS_NOISE_RST  = 30'd10737418;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_PREP,
        ST_DIV_SETUP,
        ST_DIV_RUN,
        ST_DIV_END,
        ST_MUL,
        ST_ACC,
        ST_DONE
    } state_t;

    // product schedule: gain times residual, then gain times covariance column
    typedef enum logic [2:0] {
        MS_X0,
        MS_X1,
        MS_P00,
        MS_P01,
        MS_P10,
        MS_P11
    } mstep_t;

endpackage

[design/abkf_if.sv]
// ----------------------------------------------------------------------------
// abkf stream interfaces
// Valid/ready channels for input samples and filter results.
// ----------------------------------------------------------------------------
interface abkf_in_if
    import abkf_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic [AXIS_W-1:0]         axis;
    logic signed [ACCEL_W-1:0] accel_sample;

    modport source (output valid, axis, accel_sample, input ready);
    modport sink   (input valid, axis, accel_sample, output ready);
endinterface

interface abkf_out_if
    import abkf_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic [AXIS_W-1:0]         axis_out;
    logic signed [ACCEL_W-1:0] accel_estimate_out;
    logic signed [ACCEL_W-1:0] bias_estimate_out;

    modport source (output valid, axis_out, accel_estimate_out, bias_estimate_out,
                    input ready);
    modport sink   (input valid, axis_out, accel_estimate_out, bias_estimate_out,
                    output ready);
endinterface

[design/accel_bias_kalman_filter.sv]
// ----------------------------------------------------------------------------
// accel_bias_kalman_filter
// Per-axis two-state (acceleration, bias) Kalman filter, Q16.16 samples and
// Q2.30 covariances, built around one shared divider and one multiplier.
// ----------------------------------------------------------------------------
//  channel   | direction | transfer when         | payload
//  ----------+-----------+-----------------------+-------------------------------
//  sample    | in        | valid & ready         | axis, accel_sample
//  result    | out       | valid & ready         | axis_out, accel/bias estimate
//  cfg       | in        | cfg_we (no handshake) | cfg_index, cfg_data
//
//  An in-range sample goes from transfer to result through load and
//  prepare, two 32-step restoring divisions for the gains (both skipped
//  when the innovation variance is not positive), six multiply/round passes
//  through the single multiplier, and a step that loads the result register.
//  An out-of-range axis goes from load straight to that step. The next
//  sample can transfer in the cycle after the result is loaded.
//  One sample is in flight at a time; the result register lets the next
//  sample transfer while a result waits, and a full result register holds
//  the sequencer only at its final step.
//  Reset clears all axis state to the initial estimate and covariance.
// ----------------------------------------------------------------------------
module accel_bias_kalman_filter
    import abkf_pkg::*;
#(
    parameter int AXIS_COUNT = 3
) (
    input  logic                  clk,
    input  logic                  rst_n,
    abkf_in_if.sink               sample,
    abkf_out_if.source            result,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [NOISE_W-1:0]    cfg_data
);

    localparam int AXW = (AXIS_COUNT > 1) ? $clog2(AXIS_COUNT) : 1;

    localparam logic signed [39:0] S32_MAX = 40'sd2147483647;
    localparam logic signed [39:0] S32_MIN = -40'sd2147483648;

    // Clamp a wide signed value into the signed 32-bit range.
    function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
        logic signed [31:0] r;
        if (v > S32_MAX)
        begin
            r = 32'sh7FFF_FFFF;
        end
        else if (v < S32_MIN)
        begin
            r = 32'sh8000_0000;
        end
        else
        begin
            r = v[31:0];
        end
        return r;
    endfunction

    // Per-axis filter state
    logic signed [31:0] xa_reg [AXIS_COUNT];
    logic signed [31:0] xb_reg [AXIS_COUNT];
    logic signed [31:0] pee_reg [AXIS_COUNT];
    logic signed [31:0] peu_reg [AXIS_COUNT];
    logic signed [31:0] pel_reg [AXIS_COUNT];
    logic signed [31:0] pbb_reg [AXIS_COUNT];

    logic [NOISE_W-1:0] apn_reg, bpn_reg, mn_reg;

    state_t state_reg, state_next;
    mstep_t step_reg;

    // Working registers for the sample in flight
    logic [AXIS_W-1:0]  ax_reg;
    logic [AXW-1:0]     idx;
    logic               oor_reg;
    logic signed [31:0] z_reg;
    logic signed [31:0] x0_reg, x1_reg;
    logic signed [33:0] p00_reg, p01_reg, p10_reg, p11_reg;
    logic signed [35:0] s_reg;
    logic signed [34:0] num0_reg, num1_reg, c0_reg, c1_reg, y_reg;
    logic signed [31:0] k0_reg, k1_reg;

    // Divider
    logic               div_sel_reg;
    logic [34:0]        rem_reg;
    logic [31:0]        dlo_reg;
    logic [31:0]        q_reg;
    logic [4:0]         cnt_reg;
    logic               ovf_reg;
    logic               dneg_reg;
    logic [34:0]        dvs;
    logic signed [34:0] dnum;
    logic [34:0]        dmag;
    logic [64:0]        dividend;
    logic [35:0]        rem_sh;
    logic               rem_ge;
    logic signed [31:0] k_sat;

    // Multiplier
    logic signed [31:0] ma;
    logic signed [34:0] mb;
    logic [31:0]        ma_mag;
    logic [34:0]        mb_mag;
    logic [66:0]        prod_reg;
    logic               pneg_reg;
    logic [36:0]        rnd;
    logic signed [39:0] rs;

    // Output register
    logic               out_valid_reg;
    logic [AXIS_W-1:0]  axis_out_reg;
    logic signed [31:0] est_out_reg, bias_out_reg;

    logic in_xfer, load_out, s_pos;

    assign idx       = AXW'(ax_reg);
    assign in_xfer   = sample.valid && sample.ready;
    assign load_out  = (state_reg == ST_DONE) && (!out_valid_reg || result.ready);
    assign s_pos     = (s_reg > 36'sd0);
    assign dvs       = s_reg[34:0];

    assign sample.ready              = (state_reg == ST_IDLE);
    assign result.valid              = out_valid_reg;
    assign result.axis_out           = axis_out_reg;
    assign result.accel_estimate_out = est_out_reg;
    assign result.bias_estimate_out  = bias_out_reg;

    // ------------------------------------------------------------------
    // Divider arithmetic: q = (|n| * 2^30 + s/2) / s, one quotient bit per
    // cycle. The top 33 dividend bits at or above the divisor mean the
    // quotient needs more than 32 bits and saturates.
    // ------------------------------------------------------------------
    always_comb
    begin
        dnum     = div_sel_reg ? num1_reg : num0_reg;
        dmag     = dnum[34] ? 35'(-dnum) : 35'(dnum);
        dividend = {dmag[34:0], 30'b0} + 65'(dvs >> 1);
        rem_sh   = {rem_reg, dlo_reg[31]};
        rem_ge   = (rem_sh >= 36'(dvs));
        if (dneg_reg)
        begin
            if (ovf_reg || (q_reg > 32'h8000_0000))
            begin
                k_sat = 32'sh8000_0000;
            end
            else
            begin
                k_sat = -$signed(q_reg);
            end
        end
        else
        begin
            if (ovf_reg || q_reg[31])
            begin
                k_sat = 32'sh7FFF_FFFF;
            end
            else
            begin
                k_sat = $signed(q_reg);
            end
        end
    end

    // ------------------------------------------------------------------
    // Multiplier operand select and rounding of the registered product.
    // ------------------------------------------------------------------
    always_comb
    begin
        case (step_reg)
            MS_X0:
            begin
                ma = k0_reg;
                mb = y_reg;
            end
            MS_X1:
            begin
                ma = k1_reg;
                mb = y_reg;
            end
            MS_P00:
            begin
                ma = k0_reg;
                mb = c0_reg;
            end
            MS_P01:
            begin
                ma = k0_reg;
                mb = c1_reg;
            end
            MS_P10:
            begin
                ma = k1_reg;
                mb = c0_reg;
            end
            MS_P11:
            begin
                ma = k1_reg;
                mb = c1_reg;
            end
            default:
            begin
                ma = k0_reg;
                mb = y_reg;
            end
        endcase
        ma_mag = ma[31] ? 32'(-ma) : 32'(ma);
        mb_mag = mb[34] ? 35'(-mb) : 35'(mb);
        rnd    = 37'((prod_reg + 67'(1 << 29)) >> 30);
        rs     = pneg_reg ? -$signed({3'b0, rnd}) : $signed({3'b0, rnd});
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                // skip all arithmetic for an axis with no state
                if (32'(ax_reg) >= AXIS_COUNT)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                state_next = ST_DIV_SETUP;
            end
            ST_DIV_SETUP:
            begin
                // a non-positive innovation variance gives zero gains
                state_next = s_pos ? ST_DIV_RUN : ST_MUL;
            end
            ST_DIV_RUN:
            begin
                if (cnt_reg == 5'(DIV_STEPS - 1))
                begin
                    state_next = ST_DIV_END;
                end
            end
            ST_DIV_END:
            begin
                state_next = div_sel_reg ? ST_MUL : ST_DIV_SETUP;
            end
            ST_MUL:
            begin
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                state_next = (step_reg == MS_P11) ? ST_DONE : ST_MUL;
            end
            ST_DONE:
            begin
                if (load_out)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Datapath working registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    ax_reg <= sample.axis;
                    z_reg  <= sample.accel_sample;
                end
            end
            ST_LOAD:
            begin
                // predict: identity transition, process noise on the diagonal
                oor_reg <= (32'(ax_reg) >= AXIS_COUNT);
                x0_reg  <= xa_reg[idx];
                x1_reg  <= xb_reg[idx];
                p00_reg <= 34'(pee_reg[idx]) + 34'(apn_reg);
                p01_reg <= 34'(peu_reg[idx]);
                p10_reg <= 34'(pel_reg[idx]);
                p11_reg <= 34'(pbb_reg[idx]) + 34'(bpn_reg);
            end
            ST_PREP:
            begin
                s_reg    <= 36'(p00_reg) + 36'(p01_reg) + 36'(p10_reg) + 36'(p11_reg)
                            + 36'(mn_reg);
                num0_reg <= 35'(p00_reg) + 35'(p01_reg);
                num1_reg <= 35'(p10_reg) + 35'(p11_reg);
                c0_reg   <= 35'(p00_reg) + 35'(p10_reg);
                c1_reg   <= 35'(p01_reg) + 35'(p11_reg);
                y_reg    <= 35'(z_reg) - (35'(x0_reg) + 35'(x1_reg));
                k0_reg   <= '0;
                k1_reg   <= '0;
                div_sel_reg <= 1'b0;
                step_reg <= MS_X0;
            end
            ST_DIV_SETUP:
            begin
                ovf_reg  <= (35'(dividend[64:32]) >= dvs);
                rem_reg  <= 35'(dividend[64:32]);
                dlo_reg  <= dividend[31:0];
                dneg_reg <= dnum[34];
                q_reg    <= '0;
                cnt_reg  <= '0;
            end
            ST_DIV_RUN:
            begin
                rem_reg <= rem_ge ? 35'(rem_sh - 36'(dvs)) : rem_sh[34:0];
                q_reg   <= {q_reg[30:0], rem_ge};
                dlo_reg <= {dlo_reg[30:0], 1'b0};
                cnt_reg <= cnt_reg + 5'd1;
            end
            ST_DIV_END:
            begin
                if (div_sel_reg)
                begin
                    k1_reg <= k_sat;
                end
                else
                begin
                    k0_reg <= k_sat;
                end
                div_sel_reg <= 1'b1;
            end
            ST_MUL:
            begin
                prod_reg <= 67'(ma_mag) * 67'(mb_mag);
                pneg_reg <= ma[31] ^ mb[34];
            end
            ST_ACC:
            begin
                // update estimate and covariance, one term per pass
                case (step_reg)
                    MS_X0:   x0_reg  <= sat32(40'(x0_reg) + rs);
                    MS_X1:   x1_reg  <= sat32(40'(x1_reg) + rs);
                    MS_P00:  p00_reg <= 34'(sat32(40'(p00_reg) - rs));
                    MS_P01:  p01_reg <= 34'(sat32(40'(p01_reg) - rs));
                    MS_P10:  p10_reg <= 34'(sat32(40'(p10_reg) - rs));
                    MS_P11:  p11_reg <= 34'(sat32(40'(p11_reg) - rs));
                    default: x0_reg  <= x0_reg;
                endcase
                step_reg <= mstep_t'(step_reg + 3'd1);
            end
            default:
            begin
                step_reg <= step_reg;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Axis state and noise registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < AXIS_COUNT; i++)
            begin
                xa_reg[i]  <= '0;
                xb_reg[i]  <= '0;
                pee_reg[i] <= Q30_ONE;
                peu_reg[i] <= '0;
                pel_reg[i] <= '0;
                pbb_reg[i] <= Q30_ONE;
            end
            apn_reg <= ACCEL_NOISE_RST;
            bpn_reg <= BIAS_NOISE_RST;
            mn_reg  <= MEAS_NOISE_RST;
        end
        else
        begin
            if (load_out && !oor_reg)
            begin
                xa_reg[idx]  <= x0_reg;
                xb_reg[idx]  <= x1_reg;
                pee_reg[idx] <= p00_reg[31:0];
                peu_reg[idx] <= p01_reg[31:0];
                pel_reg[idx] <= p10_reg[31:0];
                pbb_reg[idx] <= p11_reg[31:0];
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_ACCEL_NOISE: apn_reg <= cfg_data;
                    REG_BIAS_NOISE:  bpn_reg <= cfg_data;
                    REG_MEAS_NOISE:  mn_reg  <= cfg_data;
                    default:         apn_reg <= apn_reg;
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Result register: hold until transferred
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            axis_out_reg <= ax_reg;
            est_out_reg  <= oor_reg ? '0 : x0_reg;
            bias_out_reg <= oor_reg ? '0 : x1_reg;
        end
    end

endmodule

[design/abkf_checker.sv]
// ----------------------------------------------------------------------------
// abkf_checker
// Port-level checks for the accelerometer Kalman filter, bound to the top.
// ----------------------------------------------------------------------------
module abkf_checker
    import abkf_pkg::*;
#(
    parameter int AXIS_COUNT = 3
) (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      in_valid,
    input logic                      in_ready,
    input logic                      out_valid,
    input logic                      out_ready,
    input logic [AXIS_W-1:0]         out_axis,
    input logic signed [ACCEL_W-1:0] out_est,
    input logic signed [ACCEL_W-1:0] out_bias
);

    // a stalled result stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // one sample at a time: no second transfer right after one
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("sample taken while busy");

    // an axis without state reports zero estimates
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (32'(out_axis) >= AXIS_COUNT) |-> (out_est == '0) && (out_bias == '0))
        else $error("out-of-range axis with nonzero estimate");

endmodule

bind accel_bias_kalman_filter abkf_checker #(.AXIS_COUNT(AXIS_COUNT)) u_abkf_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sample.valid),
    .in_ready  (sample.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_axis  (result.axis_out),
    .out_est   (result.accel_estimate_out),
    .out_bias  (result.bias_estimate_out)
);
